// ----- hdl/rrm_pkg.sv -----
// ----------------------------------------------------------------------------
// rrm_pkg
// Types, codes and helpers shared by the reflection reference match unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rrm_pkg;

	localparam int unsigned RES_W   = 24;
	localparam int unsigned CNT_W   = 21;
	localparam int unsigned PHASE_W = 12;
	localparam int unsigned N_W     = 16;

	localparam logic [RES_W-1:0] RES_SAT   = '1;
	localparam logic [CNT_W-1:0] COUNT_SAT = '1;
	localparam logic [PHASE_W-1:0] PHASE_FULL = 12'd3600;
	localparam logic [PHASE_W:0]   PHASE_TWO  = 13'd7200;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_QUERY = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_LOADED  = 3'd0,
		ST_FULL    = 3'd1,
		ST_MATCHED = 3'd2,
		ST_NOMATCH = 3'd3,
		ST_OUTSIDE = 3'd4,
		ST_CLEARED = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		REG_CELL    = 3'd0,
		REG_AMP_FLR = 3'd1,
		REG_IQ_MAX  = 3'd2,
		REG_RES_MIN = 3'd3,
		REG_RES_MAX = 3'd4,
		REG_FRIEDEL = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_RES,
		FSM_SCAN,
		FSM_DONE
	} fsm_t;

	typedef struct packed {
		logic signed [8:0]  h;
		logic signed [8:0]  k;
		logic signed [31:0] amp;
		logic [PHASE_W-1:0] phase;
		logic [3:0]         quality;
	} entry_t;

	typedef struct packed {
		logic           start;
		logic [N_W-1:0] n;
	} res_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [RES_W-1:0] value;
	} res_rsp_t;

	function automatic logic [PHASE_W-1:0] neg_phase(input logic [PHASE_W-1:0] ph);
		logic [PHASE_W:0] t;
		t = '0;
		if (ph == '0)
			t = '0;
		else if (ph <= PHASE_FULL)
			t = {1'b0, PHASE_FULL} - {1'b0, ph};
		else
			t = PHASE_TWO - {1'b0, ph};
		return t[PHASE_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- hdl/rrm_if.sv -----
// ----------------------------------------------------------------------------
// rrm_if
// Handshake channels of the reflection reference match unit.
// ----------------------------------------------------------------------------
`default_nettype none
interface rrm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic signed [7:0]  h_index;
	logic signed [7:0]  k_index;
	logic signed [31:0] amplitude;
	logic [11:0] phase;
	logic [3:0]  quality;
	modport source (output valid, mode, h_index, k_index, amplitude, phase, quality,
		input ready);
	modport sink (input valid, mode, h_index, k_index, amplitude, phase, quality,
		output ready);
endinterface

interface rrm_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        weight;
	logic [11:0] ref_phase;
	logic [23:0] resolution;
	logic [20:0] match_count;
	modport source (output valid, status, weight, ref_phase, resolution, match_count,
		input ready);
	modport sink (input valid, status, weight, ref_phase, resolution, match_count,
		output ready);
endinterface

interface rrm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  addr;
	logic [31:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/reflection_reference_match_unit.sv -----
// ----------------------------------------------------------------------------
// reflection_reference_match_unit
// Loads reference reflections and matches queries against them in load order.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req      in   valid/ready   mode, h_index, k_index, amplitude, phase, quality
//  rsp      out  valid/ready   status, weight, ref_phase, resolution, match_count
//  cfg      in   valid/ready   addr (register index), data
//
//  Load, clear and unused mode: result registered at accept.
//  Query: the bit-serial resolution unit forms the 24 result bits, then signals done;
//  then the scan reads the loaded entries in order through the registered table read port,
//  then the result is registered; a query outside the limits skips the scan.
//  Reset restores the register defaults and zeroes the counts; table contents
//  are unused until loaded.
//  A new item is taken only when idle and the output register is free or being taken.
`default_nettype none
module reflection_reference_match_unit #(
	parameter int unsigned REF_DEPTH = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rrm_req_if.sink   req,
	rrm_rsp_if.source rsp,
	rrm_cfg_if.sink   cfg
);
	import rrm_pkg::*;

	localparam int unsigned AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
	localparam int unsigned CW = $clog2(REF_DEPTH + 1);

	logic [RES_W-1:0]   cell_q, res_min_q, res_max_q;
	logic signed [31:0] amp_floor_q;
	logic [3:0]         iq_max_q;
	logic               friedel_q;

	fsm_t state_q, state_d;
	logic [CW-1:0]    ref_count_q, iss_q;
	logic [CNT_W-1:0] total_q;
	logic             rv_s1;

	entry_t           qry_q;
	logic [RES_W-1:0] res_q;

	logic             out_valid_q;
	status_t          out_status_q;
	logic             out_weight_q;
	logic [PHASE_W-1:0] out_phase_q;
	logic [RES_W-1:0] out_res_q;
	logic [CNT_W-1:0] out_cnt_q;

	logic out_free, accept, neg;
	mode_t mode;
	entry_t norm;
	logic signed [17:0] hh, kk;
	logic [17:0] nsum;
	res_req_t res_req;
	res_rsp_t res_rsp;
	logic issue, hit, outside, finish;
	status_t fin_status_q;
	entry_t rdata;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q      <= 24'd25600;
			amp_floor_q <= '0;
			iq_max_q    <= 4'd7;
			res_min_q   <= '0;
			res_max_q   <= RES_SAT;
			friedel_q   <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_CELL:    cell_q      <= cfg.data[RES_W-1:0];
				REG_AMP_FLR: amp_floor_q <= cfg.data;
				REG_IQ_MAX:  iq_max_q    <= cfg.data[3:0];
				REG_RES_MIN: res_min_q   <= cfg.data[RES_W-1:0];
				REG_RES_MAX: res_max_q   <= cfg.data[RES_W-1:0];
				REG_FRIEDEL: friedel_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == FSM_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign mode      = mode_t'(req.mode);

	always_comb begin
		neg = friedel_q && (mode == MODE_LOAD || mode == MODE_QUERY)
			&& (req.h_index < 0 || (req.h_index == 0 && req.k_index < 0));
		norm.h       = neg ? -{req.h_index[7], req.h_index} : {req.h_index[7], req.h_index};
		norm.k       = neg ? -{req.k_index[7], req.k_index} : {req.k_index[7], req.k_index};
		norm.amp     = req.amplitude;
		norm.phase   = neg ? neg_phase(req.phase) : req.phase;
		norm.quality = req.quality;
		hh   = norm.h * norm.h;
		kk   = norm.k * norm.k;
		nsum = hh + kk;
		res_req.start = accept && mode == MODE_QUERY;
		res_req.n     = nsum[N_W-1:0];
	end

	rrm_res_unit u_res (
		.clk      (clk),
		.arst_n   (arst_n),
		.cell_len (cell_q),
		.req      (res_req),
		.rsp      (res_rsp)
	);

	assign issue = (state_q == FSM_SCAN) && (iss_q < ref_count_q) && !hit;

	rrm_ref_mem #(.DEPTH(REF_DEPTH), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (accept && mode == MODE_LOAD && ref_count_q < CW'(REF_DEPTH)),
		.waddr (ref_count_q[AW-1:0]),
		.wdata (norm),
		.re    (issue),
		.raddr (iss_q[AW-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		hit = (state_q == FSM_SCAN) && rv_s1 && rdata.h == qry_q.h && rdata.k == qry_q.k
			&& !(rdata.amp < amp_floor_q) && rdata.quality <= iq_max_q;
		outside = qry_q.amp < amp_floor_q || qry_q.quality > iq_max_q
			|| res_rsp.value < res_min_q || res_rsp.value > res_max_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= FSM_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		finish  = 1'b0;
		unique case (state_q)
			FSM_IDLE: if (res_req.start) state_d = FSM_RES;
			FSM_RES: begin
				if (res_rsp.done) state_d = outside ? FSM_DONE : FSM_SCAN;
			end
			FSM_SCAN: begin
				if (hit || (!rv_s1 && iss_q == ref_count_q)) state_d = FSM_DONE;
			end
			FSM_DONE: begin
				finish = out_free;
				if (out_free) state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_count_q <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			rv_s1       <= 1'b0;
			iss_q       <= '0;
		end else begin
			rv_s1 <= issue;
			if (issue) iss_q <= iss_q + CW'(1);
			if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
			if (accept) begin
				out_valid_q <= mode != MODE_QUERY;
				iss_q       <= '0;
				if (mode == MODE_LOAD && ref_count_q < CW'(REF_DEPTH))
					ref_count_q <= ref_count_q + CW'(1);
				if (mode == MODE_CLEAR) begin
					ref_count_q <= '0;
					total_q     <= '0;
				end
			end
			if (finish) begin
				out_valid_q <= 1'b1;
				if (fin_status_q == ST_MATCHED && total_q != COUNT_SAT)
					total_q <= total_q + CNT_W'(1);
			end
		end
	end

	// hold the query and its result while working
	always_ff @(posedge clk) begin
		if (accept) qry_q <= norm;
		if (state_q == FSM_RES && res_rsp.done) begin
			res_q        <= res_rsp.value;
			fin_status_q <= outside ? ST_OUTSIDE : ST_NOMATCH;
		end
		if (hit) begin
			fin_status_q <= ST_MATCHED;
			out_phase_q  <= rdata.phase;
		end
		if (accept) begin
			out_weight_q <= 1'b0;
			out_phase_q  <= '0;
			out_res_q    <= '0;
			out_cnt_q    <= (mode == MODE_CLEAR) ? '0 : total_q;
			unique case (mode)
				MODE_LOAD:  out_status_q <= (ref_count_q < CW'(REF_DEPTH)) ? ST_LOADED : ST_FULL;
				MODE_CLEAR: out_status_q <= ST_CLEARED;
				MODE_QUERY: out_status_q <= ST_NOMATCH;
				MODE_NONE:  out_status_q <= ST_OUTSIDE;
				default:    out_status_q <= ST_OUTSIDE;
			endcase
		end
		if (finish) begin
			out_status_q <= fin_status_q;
			out_weight_q <= fin_status_q == ST_MATCHED;
			out_res_q    <= res_q;
			if (fin_status_q != ST_MATCHED) out_phase_q <= '0;
			out_cnt_q    <= (fin_status_q == ST_MATCHED && total_q != COUNT_SAT)
				? total_q + CNT_W'(1) : total_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.weight      = out_weight_q;
	assign rsp.ref_phase   = out_phase_q;
	assign rsp.resolution  = out_res_q;
	assign rsp.match_count = out_cnt_q;

	a_weight_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_weight_q == (out_status_q == ST_MATCHED)))
		else $error("weight disagrees with status");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ref_count_q <= CW'(REF_DEPTH) && iss_q <= ref_count_q)
		else $error("table count or scan index out of range");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == MODE_CLEAR) |=> (ref_count_q == '0 && total_q == '0))
		else $error("clear did not empty table");
	a_scan_idle_mem: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> !(req.valid && req.ready))
		else $error("item accepted during scan");
endmodule
`default_nettype wire

// ----- hdl/rrm_res_unit.sv -----
// ----------------------------------------------------------------------------
// rrm_res_unit
// Resolution floor(cell / sqrt(n)), one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rrm_res_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [rrm_pkg::RES_W-1:0]   cell_len,
	input  wire rrm_pkg::res_req_t           req,
	output rrm_pkg::res_rsp_t                rsp
);
	import rrm_pkg::*;

	logic             busy_q, done_q;
	logic [4:0]       b_q;
	logic [RES_W-1:0] r_q;
	logic [63:0]      p_q;
	logic [39:0]      qq_q;
	logic [47:0]      c2_q;
	logic [N_W-1:0]   n_q;
	logic [65:0]      trial;
	logic             fits;

	always_comb begin
		trial = {2'b00, p_q} + ({26'd0, qq_q} << ({1'b0, b_q} + 6'd1))
			+ ({50'd0, n_q} << ({1'b0, b_q} << 1));
		fits  = trial <= {18'd0, c2_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= req.n != '0;
				done_q <= req.n == '0;
			end else if (busy_q && b_q == 5'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			c2_q <= cell_len * cell_len;
			n_q  <= req.n;
			b_q  <= 5'(RES_W - 1);
			p_q  <= '0;
			qq_q <= '0;
			r_q  <= (req.n == '0) ? RES_SAT : '0;
		end else if (busy_q) begin
			b_q <= b_q - 5'd1;
			if (fits) begin
				p_q  <= trial[63:0];
				qq_q <= qq_q + ({24'd0, n_q} << b_q);
				r_q  <= r_q | (RES_W'(1) << b_q);
			end
		end
	end

	assign rsp = '{busy: busy_q, done: done_q, value: r_q};

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) || $past(req.start))
		else $error("resolution done without work");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("resolution started while busy");
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("resolution done while busy");
endmodule
`default_nettype wire

// ----- hdl/rrm_ref_mem.sv -----
// ----------------------------------------------------------------------------
// rrm_ref_mem
// Reference table storage, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rrm_ref_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire rrm_pkg::entry_t   wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output rrm_pkg::entry_t        rdata
);
	import rrm_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- verif/rrm_match_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rrm_match_checker
// Watches the request, response and register channels of the match unit. It
// keeps its own copy of the reference table, counters and limits, works out
// the response of every accepted request, and compares each accepted
// response field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module rrm_match_checker (
	input  logic clk,
	input  logic arst_n,
	rrm_req_if   req,
	rrm_rsp_if   rsp,
	rrm_cfg_if   cfg,
	output int   errors,
	output int   pending,
	output int   n_matched,
	output int   n_full,
	output int   n_outside
);
	import rrm_pkg::*;

	localparam int TABLE_DEPTH = 1024;

	typedef struct {
		status_t           status;
		logic              weight;
		logic [11:0]       ref_phase;
		logic [RES_W-1:0]  resolution;
		logic [CNT_W-1:0]  match_count;
	} match_result_t;

	match_result_t     result_q[$];
	entry_t            ref_mem[TABLE_DEPTH];
	int                stored;
	logic [CNT_W-1:0]  match_tot;

	logic [23:0]        cell_len;
	logic signed [31:0] floor_amp;
	logic [3:0]         q_max;
	logic [23:0]        win_lo;
	logic [23:0]        win_hi;
	logic               friedel_on;

	assign pending = result_q.size();

	function automatic logic [RES_W-1:0] calc_resolution(int h, int k);
		longint unsigned n, c2, lo, hi, mid;
		n = longint'(h * h + k * k);
		if (n == 0)
			return RES_SAT;
		c2 = longint'(cell_len) * longint'(cell_len);
		lo = 0;
		hi = 64'(cell_len);
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (mid * mid * n <= c2)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo[RES_W-1:0];
	endfunction

	function automatic match_result_t predict_match(logic [1:0] mode, logic signed [7:0] hi8,
			logic signed [7:0] ki8, logic signed [31:0] amp, logic [11:0] ph_in,
			logic [3:0] q);
		match_result_t r;
		int h, k;
		logic [11:0] ph;
		h = hi8;
		k = ki8;
		ph = ph_in;
		r = '{ST_OUTSIDE, 1'b0, 12'd0, '0, '0};
		if (friedel_on && (mode == MODE_LOAD || mode == MODE_QUERY) &&
				(h < 0 || (h == 0 && k < 0))) begin
			h = -h;
			k = -k;
			if (ph != 0)
				ph = 12'((ph <= 12'd3600) ? 13'd3600 - ph : 13'd7200 - ph);
		end
		case (mode)
			MODE_LOAD: begin
				if (stored < TABLE_DEPTH) begin
					ref_mem[stored] = '{h[8:0], k[8:0], amp, ph, q};
					stored++;
					r.status = ST_LOADED;
				end else
					r.status = ST_FULL;
			end
			MODE_QUERY: begin
				r.resolution = calc_resolution(h, k);
				if (amp < floor_amp || q > q_max || r.resolution < win_lo ||
						r.resolution > win_hi)
					r.status = ST_OUTSIDE;
				else begin
					r.status = ST_NOMATCH;
					for (int i = 0; i < stored; i++) begin
						if (ref_mem[i].h == h && ref_mem[i].k == k &&
								ref_mem[i].amp >= floor_amp && ref_mem[i].quality <= q_max) begin
							r.status = ST_MATCHED;
							r.weight = 1'b1;
							r.ref_phase = ref_mem[i].phase;
							if (match_tot != COUNT_SAT)
								match_tot++;
							break;
						end
					end
				end
			end
			MODE_CLEAR: begin
				stored = 0;
				match_tot = '0;
				r.status = ST_CLEARED;
			end
			default: ;
		endcase
		r.match_count = match_tot;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		match_result_t e;
		if (!arst_n) begin
			result_q.delete();
			stored = 0;
			match_tot = '0;
			cell_len = 24'd25600;
			floor_amp = 0;
			q_max = 4'd7;
			win_lo = '0;
			win_hi = '1;
			friedel_on = 1'b1;
			errors = 0;
			n_matched = 0;
			n_full = 0;
			n_outside = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.addr)
					REG_CELL:    cell_len = cfg.data[23:0];
					REG_AMP_FLR: floor_amp = cfg.data;
					REG_IQ_MAX:  q_max = cfg.data[3:0];
					REG_RES_MIN: win_lo = cfg.data[23:0];
					REG_RES_MAX: win_hi = cfg.data[23:0];
					REG_FRIEDEL: friedel_on = cfg.data[0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				e = predict_match(req.mode, req.h_index, req.k_index, req.amplitude,
					req.phase, req.quality);
				if (e.status == ST_MATCHED) n_matched++;
				if (e.status == ST_FULL) n_full++;
				if (e.status == ST_OUTSIDE) n_outside++;
				result_q.push_back(e);
			end
			if (rsp.valid && rsp.ready) begin
				if (result_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected item status=%0d", $realtime, rsp.status);
				end else begin
					e = result_q.pop_front();
					if (rsp.status !== e.status || rsp.weight !== e.weight ||
							rsp.ref_phase !== e.ref_phase || rsp.resolution !== e.resolution ||
							rsp.match_count !== e.match_count) begin
						errors++;
						if (errors <= 10)
							$display({"%0t: mismatch exp st=%0d w=%0d ph=%0d res=%0d cnt=%0d,",
								" got st=%0d w=%0d ph=%0d res=%0d cnt=%0d"},
								$realtime, e.status, e.weight, e.ref_phase, e.resolution,
								e.match_count, rsp.status, rsp.weight, rsp.ref_phase,
								rsp.resolution, rsp.match_count);
					end
				end
			end
		end
	end

endmodule

// ----- verif/reflection_reference_match_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reflection_reference_match_unit_tb
// Drives loads, queries, clears and unused modes into the match unit under
// several limit settings, loads a long run of entries for long scans, and
// applies random gaps and stalls on both channels. A checker beside the unit
// predicts and compares every response.
// ----------------------------------------------------------------------------
module reflection_reference_match_unit_tb;
	import rrm_pkg::*;

	localparam int WATCHDOG_LIMIT = 8000;

	logic clk;
	logic arst_n;
	int   errors, pending, n_matched, n_full, n_outside;
	int   items_sent;
	int   idle_cycles;
	bit   quiet;
	bit   long_hold;
	int   stall_left;
	int   hold_cnt;
	logic signed [31:0] cur_floor;

	rrm_req_if req();
	rrm_rsp_if rsp();
	rrm_cfg_if cfg();

	reflection_reference_match_unit u_top (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg)
	);

	rrm_match_checker u_checker (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg),
		.errors(errors), .pending(pending), .n_matched(n_matched),
		.n_full(n_full), .n_outside(n_outside)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [7:0] pick_index();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 8'($urandom_range(0, 6) - 3);
		if (r < 85)
			case ($urandom_range(0, 3))
				0: return -8'sd128;
				1: return 8'sd127;
				2: return 8'sd0;
				default: return -8'sd1;
			endcase
		return 8'($urandom);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (long_hold) begin
			rsp.ready <= 1'b0;
			hold_cnt++;
			if (hold_cnt >= 400) begin
				long_hold = 0;
				hold_cnt = 0;
			end
		end else if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp.ready <= 1'b1;
			if (!quiet && $urandom_range(0, 7) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_item(mode_t mode, logic signed [7:0] h, logic signed [7:0] k,
			logic signed [31:0] amp, logic [11:0] ph, logic [3:0] q);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.mode      <= mode;
		req.h_index   <= h;
		req.k_index   <= k;
		req.amplitude <= amp;
		req.phase     <= ph;
		req.quality   <= q;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [31:0] data);
		cfg.valid <= 1'b1;
		cfg.addr  <= idx;
		cfg.data  <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		if (idx == REG_AMP_FLR)
			cur_floor = data;
	endtask

	task automatic set_limits(logic [23:0] cell_len, logic [31:0] amp_floor, logic [3:0] iqm,
			logic [23:0] rmin, logic [23:0] rmax, logic fe);
		drain();
		cfg_write(REG_CELL, 32'(cell_len));
		cfg_write(REG_AMP_FLR, amp_floor);
		cfg_write(REG_IQ_MAX, 32'(iqm));
		cfg_write(REG_RES_MIN, 32'(rmin));
		cfg_write(REG_RES_MAX, 32'(rmax));
		cfg_write(REG_FRIEDEL, 32'(fe));
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_item();
		int r;
		mode_t m;
		logic signed [31:0] amp;
		r = $urandom_range(0, 99);
		m = r < 40 ? MODE_LOAD : r < 90 ? MODE_QUERY : r < 95 ? MODE_CLEAR : MODE_NONE;
		amp = ($urandom_range(0, 99) < 50) ? cur_floor + $urandom_range(0, 20) - 10
			: $urandom;
		send_item(m, pick_index(), pick_index(), amp, 12'($urandom_range(0, 3599)),
			4'($urandom_range(0, 15)));
	endtask

	initial begin
		logic [23:0] lo, hi;
		req.valid = 1'b0;
		req.mode = MODE_NONE;
		req.h_index = '0;
		req.k_index = '0;
		req.amplitude = '0;
		req.phase = '0;
		req.quality = '0;
		cfg.valid = 1'b0;
		cfg.addr = REG_CELL;
		cfg.data = '0;
		rsp.ready = 1'b0;
		items_sent = 0;
		idle_cycles = 0;
		stall_left = 0;
		hold_cnt = 0;
		quiet = 0;
		long_hold = 0;
		cur_floor = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(MODE_LOAD, -8'sd128, 8'sd5, 32'sh7fffffff, 12'd100, 4'd0);
		send_item(MODE_LOAD, 8'sd0, -8'sd3, 32'sd256, 12'd0, 4'd1);
		send_item(MODE_LOAD, 8'sd3, 8'sd4, 32'sh80000000, 12'd3599, 4'd0);
		send_item(MODE_LOAD, 8'sd3, 8'sd4, 32'sd10, 12'd2047, 4'd15);
		send_item(MODE_LOAD, -8'sd3, -8'sd4, 32'sd50, 12'd1800, 4'd2);
		send_item(MODE_LOAD, 8'sd127, 8'sd127, 32'sd0, 12'd3584, 4'd7);
		send_item(MODE_LOAD, 8'sd0, 8'sd0, 32'sd1, 12'd1, 4'd8);
		send_item(MODE_QUERY, -8'sd128, 8'sd5, 32'sd1000, 12'd0, 4'd0);
		send_item(MODE_QUERY, 8'sd0, 8'sd3, 32'sd5, 12'd200, 4'd3);
		send_item(MODE_QUERY, 8'sd3, 8'sd4, 32'sd5, 12'd200, 4'd3);
		send_item(MODE_QUERY, 8'sd127, 8'sd127, 32'sd0, 12'd1, 4'd7);
		send_item(MODE_QUERY, 8'sd0, 8'sd0, 32'sd1, 12'd1, 4'd0);
		send_item(MODE_QUERY, 8'sd3, 8'sd4, -32'sd1, 12'd10, 4'd0);
		send_item(MODE_QUERY, 8'sd3, 8'sd4, 32'sd9, 12'd10, 4'd8);
		send_item(MODE_QUERY, 8'sd1, 8'sd1, 32'sd9, 12'd10, 4'd0);
		send_item(MODE_NONE, -8'sd1, 8'sd1, 32'sd9, 12'd3599, 4'd15);
		send_item(MODE_CLEAR, 8'sd0, 8'sd0, 32'sd0, 12'd0, 4'd0);
		send_item(MODE_QUERY, -8'sd128, 8'sd5, 32'sd1000, 12'd0, 4'd0);

		set_limits(24'd1, 32'h80000000, 4'd15, 24'd0, 24'd0, 1'b0);
		send_item(MODE_LOAD, -8'sd128, -8'sd128, 32'sd0, 12'd900, 4'd15);
		send_item(MODE_QUERY, -8'sd128, -8'sd128, 32'sh80000000, 12'd0, 4'd15);
		send_item(MODE_QUERY, 8'sd1, 8'sd0, 32'sd0, 12'd0, 4'd0);
		send_item(MODE_QUERY, 8'sd0, 8'sd0, 32'sd0, 12'd0, 4'd0);

		for (int p = 0; p < 9; p++) begin
			case (p)
				0: set_limits(24'd25600, 32'd0, 4'd7, 24'd0, 24'hffffff, 1'b1);
				1: set_limits(24'hffffff, 32'h7fffffff, 4'd0, 24'd0, 24'hffffff, 1'b1);
				2: set_limits(24'd1, 32'h80000000, 4'd15, 24'd0, 24'd1, 1'b0);
				3: set_limits(24'hffffff, 32'hffffff00, 4'd15, 24'hffffff, 24'hffffff, 1'b1);
				default: begin
					lo = $urandom_range(0, 1) ? 24'd0 : 24'($urandom_range(0, 24'h4000));
					hi = $urandom_range(0, 1) ? 24'hffffff
						: 24'(lo + $urandom_range(0, 24'h40000));
					set_limits(24'($urandom_range(1, 24'hffffff)), $urandom_range(0, 3) ?
						$urandom_range(0, 2000) - 1000 : $urandom,
						4'($urandom_range(0, 15)), lo, hi, 1'($urandom_range(0, 1)));
				end
			endcase
			quiet = (p % 3 == 2);
			if (p == 4)
				long_hold = 1;
			for (int i = 0; i < 55; i++) begin
				if (i == 30 && p == 5)
					drain();
				random_item();
			end
		end

		set_limits(24'd25600, 32'd0, 4'd15, 24'd0, 24'hffffff, 1'b1);
		quiet = 1;
		send_item(MODE_CLEAR, 8'sd0, 8'sd0, 32'sd0, 12'd0, 4'd0);
		for (int i = 0; i < 60; i++)
			send_item(MODE_LOAD, 8'($urandom_range(0, 6) - 3), 8'($urandom_range(0, 6) - 3),
				$urandom_range(0, 100), 12'($urandom_range(0, 3599)),
				4'($urandom_range(0, 15)));
		quiet = 0;
		for (int i = 0; i < 6; i++)
			send_item(MODE_QUERY, 8'sd5, pick_index(), 32'sd10, 12'd0, 4'd0);
		send_item(MODE_CLEAR, 8'sd0, 8'sd0, 32'sd0, 12'd0, 4'd0);

		drain();
		repeat (60) @(posedge clk);
		$display("Sent %0d items across several limit settings and a long table scan.",
			items_sent);
		$display("Matched %0d, dropped on full table %0d, outside limits %0d.",
			n_matched, n_full, n_outside);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/rrm_pkg.sv
hdl/rrm_if.sv
hdl/rrm_res_unit.sv
hdl/rrm_ref_mem.sv
hdl/reflection_reference_match_unit.sv
verif/rrm_match_checker.sv
verif/reflection_reference_match_unit_tb.sv
